// File: hdl/nqbs_pkg.sv
// ----------------------------------------------------------------------------
// nqbs_pkg
// Shared widths, types and state codes for the N-queens backtracking solver.
// ----------------------------------------------------------------------------
package nqbs_pkg;

  localparam int MAX_SIZE = 16;
  localparam int SIZE_W   = 5;                        // board_size field
  localparam int FIELD_W  = 4;                        // column_index / queen_row fields
  localparam int IDX_W    = $clog2(MAX_SIZE);         // column / row index
  localparam int CNT_W    = $clog2(MAX_SIZE + 1);     // index that may reach MAX_SIZE
  localparam int DIAG_N   = 2 * MAX_SIZE - 1;         // diagonals on the largest board
  localparam int DIAG_W   = $clog2(DIAG_N);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_BACK,
    ST_EMIT,
    ST_FAIL
  } nqbs_state_t;

  // one request to the occupancy unit
  typedef struct packed {
    logic             set;
    logic             clr;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mask_op_t;

  // chosen-row stack access
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } stk_cmd_t;

endpackage

// File: hdl/nqbs_if.sv
// ----------------------------------------------------------------------------
// nqbs_if
// Valid/ready channels for board-size requests and per-column results.
// ----------------------------------------------------------------------------
interface nqbs_req_if;
  import nqbs_pkg::*;

  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] board_size;

  modport source (output valid, output board_size, input ready);
  modport sink   (input valid, input board_size, output ready);
endinterface

interface nqbs_res_if;
  import nqbs_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] column_index;
  logic [FIELD_W-1:0] queen_row;
  logic               found;
  logic               last_result;

  modport source (output valid, output column_index, output queen_row,
                  output found, output last_result, input ready);
  modport sink   (input valid, input column_index, input queen_row,
                  input found, input last_result, output ready);
endinterface

// File: hdl/n_queens_backtrack_solver.sv
// ----------------------------------------------------------------------------
// n_queens_backtrack_solver
// Depth-first N-queens search; returns the first placement, one result per
// column, or a single not-found result.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                        note
//  req      in   board_size[4:0]                                1 .. 16
//  res      out  column_index[3:0] queen_row[3:0] found last    1 .. 16 per req
//
//  One candidate cell is tested per cycle through the single occupancy
//  test unit, and a backtrack step is a stack fetch, then a lift; the total
//  grows steeply with board size.
//  Once a full board is noticed, one result per cycle while res.ready is high.
//  A bad size (0 or over 16) goes straight to the not-found result.
//  req.ready is high only while idle; a stalled result holds until taken.
// ----------------------------------------------------------------------------
module n_queens_backtrack_solver (
  input logic  clk,
  input logic  rst,
  nqbs_req_if.sink   req,
  nqbs_res_if.source res
);
  import nqbs_pkg::*;

  logic             clr_all;
  mask_op_t         op;
  logic [CNT_W-1:0] n;
  logic             free;
  stk_cmd_t         stk;
  logic [IDX_W-1:0] stk_rdata;

  nqbs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .board_size   (req.board_size),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .column_index (res.column_index),
    .queen_row    (res.queen_row),
    .found        (res.found),
    .last_result  (res.last_result),
    .clr_all      (clr_all),
    .op           (op),
    .n            (n),
    .free         (free),
    .stk          (stk),
    .stk_rdata    (stk_rdata)
  );

  nqbs_masks u_masks (
    .clk     (clk),
    .rst     (rst),
    .clr_all (clr_all),
    .op      (op),
    .n       (n),
    .free    (free)
  );

  nqbs_stack u_stack (
    .clk   (clk),
    .cmd   (stk),
    .rdata (stk_rdata)
  );

endmodule

// File: hdl/nqbs_masks.sv
// ----------------------------------------------------------------------------
// nqbs_masks
// Row and diagonal occupancy masks with the shared free-cell test and
// place / remove update.
// ----------------------------------------------------------------------------
module nqbs_masks (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clr_all,
  input  nqbs_pkg::mask_op_t        op,
  input  logic [nqbs_pkg::CNT_W-1:0] n,
  output logic                      free
);
  import nqbs_pkg::*;

  logic [MAX_SIZE-1:0] row_taken;
  logic [DIAG_N-1:0]   rising_diag_taken;
  logic [DIAG_N-1:0]   falling_diag_taken;
  logic [DIAG_W-1:0]   rise_idx;
  logic [DIAG_W-1:0]   fall_idx;

  assign rise_idx = DIAG_W'(op.row) + DIAG_W'(op.col);
  // column - row + n - 1, never negative for a cell on the board
  assign fall_idx = DIAG_W'(op.col) + DIAG_W'(n) - DIAG_W'(1) - DIAG_W'(op.row);

  assign free = !row_taken[op.row] && !rising_diag_taken[rise_idx]
             && !falling_diag_taken[fall_idx];

  always_ff @(posedge clk) begin
    if (rst || clr_all) begin
      row_taken          <= '0;
      rising_diag_taken  <= '0;
      falling_diag_taken <= '0;
    end else if (op.set) begin
      row_taken[op.row]            <= 1'b1;
      rising_diag_taken[rise_idx]  <= 1'b1;
      falling_diag_taken[fall_idx] <= 1'b1;
    end else if (op.clr) begin
      row_taken[op.row]            <= 1'b0;
      rising_diag_taken[rise_idx]  <= 1'b0;
      falling_diag_taken[fall_idx] <= 1'b0;
    end
  end

endmodule

// File: hdl/nqbs_stack.sv
// ----------------------------------------------------------------------------
// nqbs_stack
// Per-column stack of chosen rows, one write port and one registered read port.
// ----------------------------------------------------------------------------
module nqbs_stack (
  input  logic                       clk,
  input  nqbs_pkg::stk_cmd_t         cmd,
  output logic [nqbs_pkg::IDX_W-1:0] rdata
);
  import nqbs_pkg::*;

  logic [IDX_W-1:0] chosen_row [MAX_SIZE];

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      chosen_row[cmd.waddr] <= cmd.wdata;
    end
  end

  // read data appears the cycle after the address
  always_ff @(posedge clk) begin
    rdata <= chosen_row[cmd.raddr];
  end

endmodule

// File: hdl/nqbs_ctrl.sv
// ----------------------------------------------------------------------------
// nqbs_ctrl
// Search sequencer: one candidate cell per cycle, backtrack steps as a stack
// fetch then a lift, then streams the placement out column by column.
// ----------------------------------------------------------------------------
module nqbs_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  // request channel
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic [nqbs_pkg::SIZE_W-1:0]  board_size,
  // result channel
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [nqbs_pkg::FIELD_W-1:0] column_index,
  output logic [nqbs_pkg::FIELD_W-1:0] queen_row,
  output logic                         found,
  output logic                         last_result,
  // occupancy unit
  output logic                         clr_all,
  output nqbs_pkg::mask_op_t           op,
  output logic [nqbs_pkg::CNT_W-1:0]   n,
  input  logic                         free,
  // row stack
  output nqbs_pkg::stk_cmd_t           stk,
  input  logic [nqbs_pkg::IDX_W-1:0]   stk_rdata
);
  import nqbs_pkg::*;

  nqbs_state_t      state, state_next;
  logic [CNT_W-1:0] n_next;
  logic [CNT_W-1:0] col, col_next;
  logic [CNT_W-1:0] row, row_next;
  logic [IDX_W-1:0] ecol, ecol_next;
  logic [CNT_W-1:0] col_m1;
  logic             emit_last;
  logic             size_bad;

  assign col_m1    = col - CNT_W'(1);
  assign emit_last = (CNT_W'(ecol) == n - CNT_W'(1));
  assign size_bad  = (board_size == '0) || (int'(board_size) > MAX_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      col   <= '0;
    end else begin
      state <= state_next;
      col   <= col_next;
    end
  end

  always_ff @(posedge clk) begin
    n    <= n_next;
    row  <= row_next;
    ecol <= ecol_next;
  end

  always_comb begin
    state_next   = state;
    n_next       = n;
    col_next     = col;
    row_next     = row;
    ecol_next    = ecol;
    req_ready    = 1'b0;
    res_valid    = 1'b0;
    column_index = '0;
    queen_row    = '0;
    found        = 1'b0;
    last_result  = 1'b0;
    clr_all      = 1'b0;
    op.set       = 1'b0;
    op.clr       = 1'b0;
    op.row       = row[IDX_W-1:0];
    op.col       = col[IDX_W-1:0];
    stk.we       = 1'b0;
    stk.waddr    = col[IDX_W-1:0];
    stk.wdata    = row[IDX_W-1:0];
    stk.raddr    = col_m1[IDX_W-1:0];

    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          n_next   = CNT_W'(board_size);
          col_next = '0;
          row_next = '0;
          clr_all  = 1'b1;
          state_next = size_bad ? ST_FAIL : ST_SEARCH;
        end
      end

      ST_SEARCH: begin
        if (col == n) begin
          // prefetch column 0's row for the first result
          ecol_next  = '0;
          stk.raddr  = '0;
          state_next = ST_EMIT;
        end else if (row != n) begin
          if (free) begin
            op.set   = 1'b1;
            stk.we   = 1'b1;
            col_next = col + CNT_W'(1);
            row_next = '0;
          end else begin
            row_next = row + CNT_W'(1);
          end
        end else if (col == '0) begin
          state_next = ST_FAIL;
        end else begin
          // column exhausted: fetch the row chosen one column back
          state_next = ST_BACK;
        end
      end

      ST_BACK: begin
        // lift the queen one column back, resume below it
        op.clr     = 1'b1;
        op.row     = stk_rdata;
        op.col     = col_m1[IDX_W-1:0];
        col_next   = col_m1;
        row_next   = CNT_W'(stk_rdata) + CNT_W'(1);
        state_next = ST_SEARCH;
      end

      ST_EMIT: begin
        stk.raddr    = ecol;
        res_valid    = 1'b1;
        column_index = FIELD_W'(ecol);
        queen_row    = FIELD_W'(stk_rdata);
        found        = 1'b1;
        last_result  = emit_last;
        if (res_ready) begin
          if (emit_last) begin
            state_next = ST_IDLE;
          end else begin
            ecol_next = ecol + IDX_W'(1);
            stk.raddr = ecol + IDX_W'(1);
          end
        end
      end

      ST_FAIL: begin
        res_valid   = 1'b1;
        last_result = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/nqbs_checker.sv
// ----------------------------------------------------------------------------
// nqbs_checker
// Port-level checks on the solver's request/result sequencing.
// ----------------------------------------------------------------------------
module nqbs_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [nqbs_pkg::FIELD_W-1:0] res_col,
  input logic [nqbs_pkg::FIELD_W-1:0] res_row,
  input logic                         res_found,
  input logic                         res_last
);
  import nqbs_pkg::*;

  // never takes a request while a result is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !req_ready)
    else $error("request taken while result pending");

  // a request closes the input until its results are done
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("ready after request accepted");

  // the last result frees the block on the next cycle
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready && res_last) |=> req_ready)
    else $error("not ready after final result");

  // a not-found result is always the lone final one
  a_fail_is_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_found) |-> (res_last && res_col == '0 && res_row == '0))
    else $error("bad not-found result");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_col) && $stable(res_row)
                                   && $stable(res_found) && $stable(res_last)))
    else $error("stalled result changed");

endmodule

bind n_queens_backtrack_solver nqbs_checker u_nqbs_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_col   (res.column_index),
  .res_row   (res.queen_row),
  .res_found (res.found),
  .res_last  (res.last_result)
);
